[hdl/gsi_pkg.sv]
// ----------------------------------------------------------------------------
// gsi_pkg
// Types and constants for the speed-scheduled gain interpolator.
// ----------------------------------------------------------------------------
package gsi_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_EXT_W     = 7;

  localparam int VAL_W         = 16;
  localparam int DVD_W         = 32;
  localparam int DIV_CNT_W     = 6;
  localparam int LERP_STEPS    = 32;
  localparam int TIME_STEPS    = 24;
  localparam int FRAC_W        = 8;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] igain;
    logic [VAL_W-1:0] gain;
    logic [VAL_W-1:0] spd;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_LMUL,
    ST_LLOAD,
    ST_LDIV,
    ST_LSUM,
    ST_TSET,
    ST_TDIV,
    ST_TFIN,
    ST_DONE
  } state_t;

endpackage

[hdl/gain_schedule_interpolator_core.sv]
// Lookup: a table scan (one synchronous read port), then two interpolations and a
// quotient on one shared radix-2 divider. At or beyond an end breakpoint the
// interpolations are skipped, a zero segment width skips an interpolation's divide
// and a zero integral gain skips the quotient. A lookup holds the input until its
// result enters the output register; there it waits while the next request is
// taken. rst_n is synchronous, active low; the table is not cleared.
// ----------------------------------------------------------------------------
// gain_schedule_interpolator_core
// Breakpoint table of speed, proportional and integral gain; lookups
// interpolate both gains and return gain and integral time in Q8.8.
// ----------------------------------------------------------------------------
module gain_schedule_interpolator_core
  import gsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // entry_index[2:0], speed[18:3], entry_gain[34:19],
                                  // entry_integral_gain[50:35], zero fill
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // gain[15:0], integral_time[31:16]
  output logic        out_tuser   // time_saturated
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // request fields
  logic [2:0]       in_idx;
  logic [VAL_W-1:0] in_speed;
  logic [VAL_W-1:0] in_gain;
  logic [VAL_W-1:0] in_igain;
  logic [IDX_EXT_W-1:0] idx_ext;

  assign in_idx   = in_tdata[2:0];
  assign in_speed = in_tdata[18:3];
  assign in_gain  = in_tdata[34:19];
  assign in_igain = in_tdata[50:35];
  assign idx_ext  = IDX_EXT_W'(in_idx);

  state_t state_r, state_nxt;

  // table memory
  entry_t           mem [TABLE_ENTRIES];
  entry_t           rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic             in_acc;

  // scan
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] ridx_r;
  logic             rv_r, rv_nxt;
  logic             found_r;
  logic [VAL_W-1:0] v_r;
  entry_t           prev_r, e0_r, last_r, lo_r, hi_r;

  // interpolation
  logic               phase_r;
  logic signed [16:0] off_r, width_r;
  logic signed [33:0] prod_r;
  logic               neg_r;
  logic [VAL_W-1:0]   kp_r, ki_r;

  // divider
  logic [DVD_W-1:0]     quo_r;
  logic [VAL_W-1:0]     rem_r, dvs_r;
  logic [DIV_CNT_W-1:0] dcnt_r;

  // result
  logic [VAL_W-1:0] t_r;
  logic             sat_r;
  logic [VAL_W-1:0] gain_out_r, time_out_r;
  logic             sat_out_r;
  logic             out_tvalid_r;
  logic             load_out;

  // combinational datapath helpers
  logic [VAL_W-1:0]   a0_w, a1_w;
  logic signed [16:0] delta_w;
  logic signed [33:0] prod_w;
  logic [33:0]        pmag_w;
  logic [16:0]        wmag_w;
  logic               wzero;
  logic [16:0]        sh_w, diff_w;
  logic               ge_w;
  logic [33:0]        qext_w, sum_w;
  logic [VAL_W-1:0]   lerp_w;
  logic               seg_hit;

  assign a0_w    = phase_r ? lo_r.igain : lo_r.gain;
  assign a1_w    = phase_r ? hi_r.igain : hi_r.gain;
  assign delta_w = $signed({1'b0, a1_w}) - $signed({1'b0, a0_w});
  assign prod_w  = delta_w * off_r;
  assign pmag_w  = prod_r[33] ? 34'(-prod_r) : 34'(prod_r);
  assign wmag_w  = width_r[16] ? 17'(-width_r) : 17'(width_r);
  assign wzero   = (width_r == 17'sd0);

  // one restoring step per cycle
  assign sh_w   = {rem_r, quo_r[DVD_W-1]};
  assign diff_w = sh_w - {1'b0, dvs_r};
  assign ge_w   = (sh_w >= {1'b0, dvs_r});

  // add signed quotient to the lower gain and clamp to 0..65535
  assign qext_w = {2'b00, quo_r};
  assign sum_w  = {18'b0, a0_w} + (neg_r ? (~qext_w + 34'd1) : qext_w);
  always_comb begin
    if (sum_w[33]) begin
      lerp_w = '0;
    end else if (|sum_w[32:16]) begin
      lerp_w = VAL_MAX;
    end else begin
      lerp_w = sum_w[15:0];
    end
  end

  assign seg_hit = (ridx_r != '0) && !found_r &&
                   (v_r >= prev_r.spd) && (v_r < rd_data_r.spd);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == CMD_LOOKUP) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (rv_r && ridx_r == LAST_IDX) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (v_r <= e0_r.spd || v_r >= last_r.spd) begin
          state_nxt = ST_TSET;
        end else begin
          state_nxt = ST_LMUL;
        end
      end
      ST_LMUL: begin
        if (!wzero) begin
          state_nxt = ST_LLOAD;
        end else if (phase_r) begin
          state_nxt = ST_TSET;
        end else begin
          state_nxt = ST_LMUL;
        end
      end
      ST_LLOAD: state_nxt = ST_LDIV;
      ST_LDIV: begin
        if (dcnt_r == DIV_CNT_W'(1)) state_nxt = ST_LSUM;
      end
      ST_LSUM:  state_nxt = phase_r ? ST_TSET : ST_LMUL;
      ST_TSET:  state_nxt = (ki_r == '0) ? ST_DONE : ST_TDIV;
      ST_TDIV: begin
        if (dcnt_r == DIV_CNT_W'(1)) state_nxt = ST_TFIN;
      end
      ST_TFIN:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    in_acc    = in_tvalid && in_tready;
    mem_we    = in_acc && (in_tuser == CMD_WRITE) &&
                (idx_ext < IDX_EXT_W'(TABLE_ENTRIES));
    rd_addr   = cnt_r[IDX_W-1:0];
    rv_nxt    = (state_r == ST_SCAN) && (cnt_r < CNT_W'(TABLE_ENTRIES));
    load_out  = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);
  end

  // table memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_ext[IDX_W-1:0]] <= '{igain: in_igain, gain: in_gain, spd: in_speed};
    end
    rd_data_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rv_nxt;
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    ridx_r <= rd_addr;
    unique case (state_r)
      ST_IDLE: begin
        v_r     <= in_speed;
        cnt_r   <= '0;
        found_r <= 1'b0;
        phase_r <= 1'b0;
      end
      ST_SCAN: begin
        if (rv_nxt) cnt_r <= cnt_r + CNT_W'(1);
        if (rv_r) begin
          prev_r <= rd_data_r;
          if (ridx_r == '0) begin
            e0_r <= rd_data_r;
            lo_r <= rd_data_r;
          end
          // segment 0 stands in until a holding segment turns up
          if (ridx_r == IDX_W'(1) && !found_r && !seg_hit) hi_r <= rd_data_r;
          if (seg_hit) begin
            lo_r    <= prev_r;
            hi_r    <= rd_data_r;
            found_r <= 1'b1;
          end
          if (ridx_r == LAST_IDX) last_r <= rd_data_r;
        end
      end
      ST_PICK: begin
        off_r   <= $signed({1'b0, v_r}) - $signed({1'b0, lo_r.spd});
        width_r <= $signed({1'b0, hi_r.spd}) - $signed({1'b0, lo_r.spd});
        if (v_r <= e0_r.spd) begin
          kp_r <= e0_r.gain;
          ki_r <= e0_r.igain;
        end else begin
          kp_r <= last_r.gain;
          ki_r <= last_r.igain;
        end
      end
      ST_LMUL: begin
        prod_r <= prod_w;
        if (wzero) begin
          if (phase_r) ki_r <= a0_w;
          else kp_r <= a0_w;
          phase_r <= 1'b1;
        end
      end
      ST_LLOAD: begin
        quo_r  <= pmag_w[DVD_W-1:0];
        rem_r  <= '0;
        dvs_r  <= wmag_w[VAL_W-1:0];
        neg_r  <= prod_r[33] ^ width_r[16];
        dcnt_r <= DIV_CNT_W'(LERP_STEPS);
      end
      ST_LDIV, ST_TDIV: begin
        rem_r  <= ge_w ? diff_w[VAL_W-1:0] : sh_w[VAL_W-1:0];
        quo_r  <= {quo_r[DVD_W-2:0], ge_w};
        dcnt_r <= dcnt_r - DIV_CNT_W'(1);
      end
      ST_LSUM: begin
        if (phase_r) ki_r <= lerp_w;
        else kp_r <= lerp_w;
        phase_r <= 1'b1;
      end
      ST_TSET: begin
        // dividend is gain shifted up by the fraction width, placed at the top
        quo_r  <= {kp_r, {(DVD_W - VAL_W){1'b0}}};
        rem_r  <= '0;
        dvs_r  <= ki_r;
        dcnt_r <= DIV_CNT_W'(TIME_STEPS);
        t_r    <= VAL_MAX;
        sat_r  <= 1'b1;
      end
      ST_TFIN: begin
        if (|quo_r[TIME_STEPS-1:VAL_W]) begin
          t_r   <= VAL_MAX;
          sat_r <= 1'b1;
        end else begin
          t_r   <= quo_r[VAL_W-1:0];
          sat_r <= 1'b0;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          gain_out_r <= kp_r;
          time_out_r <= t_r;
          sat_out_r  <= sat_r;
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {time_out_r, gain_out_r};
  assign out_tuser  = sat_out_r;

endmodule
